@@ src/lcm_via_euclid_gcd_defines.svh @@
// Assertion macros for the LCM block checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LCM_VIA_EUCLID_GCD_DEFINES_SVH
`define LCM_VIA_EUCLID_GCD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcm checker: same-cycle property failed");

// next-cycle implication, disabled in reset
`define LCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcm checker: next-cycle property failed");

`endif

@@ src/lcm_pkg.sv @@
// Shared constants, types and microcode table of the LCM block.
// No dependencies; used by every other file but the assertion macro header.
`default_nettype none

package lcm_pkg;

    localparam int IN_W   = 32;                 // port width of each operand
    localparam int OP_W   = 32;                 // width the operands are taken in, 8..32
    localparam int MULT_W = 64;                 // port width of the result
    localparam int KW     = $clog2(OP_W);       // common power-of-two count
    localparam int CW     = $clog2(OP_W + 1);   // divider step count
    localparam int PC_W   = 3;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_GCD,
        OP_DIVLD,
        OP_DIVSTEP,
        OP_MUL,
        OP_CLR,
        OP_PUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_ZERO,
        C_GCD_BUSY,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic operand_zero;
        logic gcd_done;
        logic div_last;
    } flags_t;

    localparam pc_t PC_IDLE = pc_t'(0);
    localparam pc_t PC_GCD  = pc_t'(2);
    localparam pc_t PC_DIV  = pc_t'(4);
    localparam pc_t PC_CLR  = pc_t'(6);
    localparam pc_t PC_PUT  = pc_t'(7);

    // Program: jump to target when the condition holds, else step on.
    // The last step wraps to the first when it falls through.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        begin
            case (pc)
                pc_t'(0): w = '{op: OP_LOAD,    cond: C_NO_ACCEPT, target: PC_IDLE};
                pc_t'(1): w = '{op: OP_NOP,     cond: C_ZERO,      target: PC_CLR};
                pc_t'(2): w = '{op: OP_GCD,     cond: C_GCD_BUSY,  target: PC_GCD};
                pc_t'(3): w = '{op: OP_DIVLD,   cond: C_NEVER,     target: PC_IDLE};
                pc_t'(4): w = '{op: OP_DIVSTEP, cond: C_DIV_BUSY,  target: PC_DIV};
                pc_t'(5): w = '{op: OP_MUL,     cond: C_ALWAYS,    target: PC_PUT};
                pc_t'(6): w = '{op: OP_CLR,     cond: C_NEVER,     target: PC_IDLE};
                pc_t'(7): w = '{op: OP_PUT,     cond: C_OUT_BUSY,  target: PC_PUT};
                default:  w = '{op: OP_NOP,     cond: C_ALWAYS,    target: PC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/lcm_in_if.sv @@
// Operand channel: valid/ready handshake carrying both operands.
// Depends on lcm_pkg.
`default_nettype none

interface lcm_in_if;
    import lcm_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] first_operand;
    logic [IN_W-1:0] second_operand;

    modport source (output valid, output first_operand, output second_operand, input ready);
    modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

`default_nettype wire

@@ src/lcm_out_if.sv @@
// Result channel: valid/ready handshake carrying the least common multiple.
// Depends on lcm_pkg.
`default_nettype none

interface lcm_out_if;
    import lcm_pkg::*;

    logic              valid;
    logic              ready;
    logic [MULT_W-1:0] multiple;

    modport source (output valid, output multiple, input ready);
    modport sink   (input valid, input multiple, output ready);
endinterface

`default_nettype wire

@@ src/lcm_datapath.sv @@
// Datapath of the LCM block: binary GCD, bit-serial divider and one multiplier.
// Driven one operation per cycle by the sequencer; depends on lcm_pkg.
`default_nettype none

module lcm_datapath (
    input  logic                        clk,
    input  lcm_pkg::op_t                op,
    input  logic [lcm_pkg::IN_W-1:0]    first_operand,
    input  logic [lcm_pkg::IN_W-1:0]    second_operand,
    output lcm_pkg::flags_t             flags,
    output logic [lcm_pkg::MULT_W-1:0]  product
);
    import lcm_pkg::*;

    logic [OP_W-1:0]     p_reg, p_next;
    logic [OP_W-1:0]     q_reg, q_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [OP_W-1:0]     a_reg, a_next;
    logic [OP_W-1:0]     b_reg, b_next;
    logic [OP_W-1:0]     d_reg, d_next;
    logic [OP_W-1:0]     rem_reg, rem_next;
    logic [OP_W-1:0]     quo_reg, quo_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [MULT_W-1:0]   prod_reg, prod_next;

    logic [OP_W:0]       trial;
    logic [OP_W:0]       diff;
    logic                fits;
    logic [2*OP_W-1:0]   mul_full;
    logic [OP_W-1:0]     p_minus_q;
    logic [OP_W-1:0]     q_minus_p;

    assign trial     = {rem_reg, quo_reg[OP_W-1]};
    assign diff      = trial - {1'b0, d_reg};
    assign fits      = !diff[OP_W];
    assign mul_full  = quo_reg * b_reg;
    assign p_minus_q = p_reg - q_reg;
    assign q_minus_p = q_reg - p_reg;

    assign flags.operand_zero = (p_reg == '0) || (q_reg == '0);
    assign flags.gcd_done     = p_reg[0] && q_reg[0] && (p_reg == q_reg);
    assign flags.div_last     = (cnt_reg == CW'(1));
    assign product            = prod_reg;

    always_comb
    begin
        p_next    = p_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        case (op)
            OP_LOAD:
            begin
                p_next = first_operand[OP_W-1:0];
                q_next = second_operand[OP_W-1:0];
                a_next = first_operand[OP_W-1:0];
                b_next = second_operand[OP_W-1:0];
                k_next = '0;
            end
            OP_GCD:
            begin
                // Stein: strip shared twos, halve a lone even value, shrink odd pairs by (big - small) / 2
                if (!p_reg[0] && !q_reg[0])
                begin
                    p_next = p_reg >> 1;
                    q_next = q_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!p_reg[0])
                begin
                    p_next = p_reg >> 1;
                end
                else if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                end
                else if (p_reg > q_reg)
                begin
                    p_next = p_minus_q >> 1;
                end
                else if (q_reg > p_reg)
                begin
                    q_next = q_minus_p >> 1;
                end
            end
            OP_DIVLD:
            begin
                d_next   = p_reg << k_reg;
                quo_next = a_reg;
                rem_next = '0;
                cnt_next = CW'(OP_W);
            end
            OP_DIVSTEP:
            begin
                // restoring division, one quotient bit a cycle
                rem_next = fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
                quo_next = {quo_reg[OP_W-2:0], fits};
                cnt_next = cnt_reg - CW'(1);
            end
            OP_MUL:
            begin
                prod_next = MULT_W'(mul_full);
            end
            OP_CLR:
            begin
                prod_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

@@ src/lcm_via_euclid_gcd.sv @@
// Channel   | dir | payload                          | handshake
// operands  | in  | first_operand, second_operand    | valid/ready
// result    | out | multiple (64 bits)               | valid/ready
//
// One item at a time. Zero operand: after the accept, the zero check jumps to a clear
// step, and the put step writes a zero result to the result register. Otherwise the
// pair runs the binary GCD loop, the divider load, the bit-serial divider steps and
// the multiply before the put step. Reset clears the program counter and result
// valid. A waiting result holds while the next item is accepted and worked on.
// Top level of the LCM block; depends on lcm_pkg, lcm_in_if, lcm_out_if, lcm_datapath.
`default_nettype none

module lcm_via_euclid_gcd (
    input  logic       clk,
    input  logic       rst_n,
    lcm_in_if.sink     operands,
    lcm_out_if.source  result
);
    import lcm_pkg::*;

    pc_t               pc_reg, pc_next;
    logic              out_valid_reg, out_valid_next;
    logic [MULT_W-1:0] out_data_reg, out_data_next;

    ucode_t            uw;
    flags_t            flags;
    logic [MULT_W-1:0] product;
    logic              in_fire;
    logic              out_busy;
    logic              take;
    logic              put;

    assign uw       = ucode_rom(pc_reg);
    assign in_fire  = operands.valid && operands.ready;
    assign out_busy = out_valid_reg && !result.ready;
    assign put      = (uw.op == OP_PUT) && !out_busy;

    assign operands.ready = (uw.op == OP_LOAD);
    assign result.valid   = out_valid_reg;
    assign result.multiple = out_data_reg;

    lcm_datapath u_datapath (
        .clk            (clk),
        .op             (uw.op),
        .first_operand  (operands.first_operand),
        .second_operand (operands.second_operand),
        .flags          (flags),
        .product        (product)
    );

    always_comb
    begin
        case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !in_fire;
            C_ZERO:      take = flags.operand_zero;
            C_GCD_BUSY:  take = !flags.gcd_done;
            C_DIV_BUSY:  take = !flags.div_last;
            C_OUT_BUSY:  take = out_busy;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = take ? uw.target : pc_t'(pc_reg + 1'b1);
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        if (put)
        begin
            out_valid_next = 1'b1;
            out_data_next  = product;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ src/lcm_checker.sv @@
// Port-level checker for the LCM block, bound to the top level.
// Depends on lcm_pkg and lcm_via_euclid_gcd_defines.svh.
`default_nettype none
`include "lcm_via_euclid_gcd_defines.svh"

module lcm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [lcm_pkg::MULT_W-1:0]  multiple
);
    import lcm_pkg::*;

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pending_reg, pending_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // items accepted and not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_fire} - {1'b0, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `LCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `LCM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(multiple))
    `LCM_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready)
    `LCM_ASSERT_IMPLY(a_no_phantom, $rose(out_valid), pending_reg != 2'd0)
    `LCM_ASSERT_IMPLY(a_pending_bound, 1'b1, pending_reg != 2'd3)

endmodule

bind lcm_via_euclid_gcd lcm_checker u_lcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .multiple  (result.multiple)
);

`default_nettype wire
